@@ rtl/ipaf_pkg.sv @@
// Shared types, codes and classification functions for the endpoint allow filter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ipaf_pkg;

    // Learned table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int USED_W = 7;

    // Operation codes
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_LEARN = 1'b1;

    // Address family codes
    localparam logic [1:0] FAM_NONE  = 2'd0;
    localparam logic [1:0] FAM_V4    = 2'd1;
    localparam logic [1:0] FAM_V6    = 2'd2;
    localparam logic [1:0] FAM_OTHER = 2'd3;

    // Learn status codes
    localparam logic [1:0] LS_INSERTED = 2'd0;
    localparam logic [1:0] LS_PRESENT  = 2'd1;
    localparam logic [1:0] LS_FULL     = 2'd2;
    localparam logic [1:0] LS_IGNORED  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_status_t;

    // Fixed IPv4 allow ranges (host order address)
    function automatic logic v4_fixed_allowed(input logic [31:0] ip);
        logic [7:0] a;
        logic [7:0] b;
        a = ip[31:24];
        b = ip[23:16];
        return (a == 8'd10) || (a == 8'd127) || (a == 8'd25) || (a == 8'd26)
            || ((a == 8'd172) && (b[7:4] == 4'h1))
            || ((a == 8'd192) && (b == 8'd168))
            || ((a == 8'd169) && (b == 8'd254))
            || (ip == 32'hFFFF_FFFF)
            || ((a == 8'd100) && (b[7:6] == 2'b01));
    endfunction

    // Loopback, unique local and link local IPv6
    function automatic logic v6_allowed(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = hi[63:56];
        b1 = hi[55:48];
        return ((hi == 64'd0) && (lo == 64'd1))
            || ((b0 & 8'hFE) == 8'hFC)
            || ((b0 == 8'hFE) && ((b1 & 8'hC0) == 8'h80));
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipaf_if.sv @@
// Request and response channel interfaces of the endpoint allow filter.
// Depends on ipaf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ipaf_req_if;
    import ipaf_pkg::*;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [1:0]  address_family;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, operation, address_family, address_high, address_low,
                    input ready);
    modport sink (input valid, operation, address_family, address_high, address_low,
                  output ready);
endinterface

interface ipaf_rsp_if;
    import ipaf_pkg::*;
    logic              valid;
    logic              ready;
    logic              allowed;
    logic [1:0]        learn_status;
    logic [USED_W-1:0] entries_used;

    modport source (output valid, allowed, learn_status, entries_used, input ready);
    modport sink (input valid, allowed, learn_status, entries_used, output ready);
endinterface

`default_nettype wire

@@ rtl/ipaf_ctrl.sv @@
// Controller state machine: sequences accept, evaluate, table scan and finish.
// Depends on ipaf_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ipaf_ctrl
    import ipaf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ipaf_dp.sv @@
// Datapath: item registers, fixed range checks, learned table memory and scan,
// and the result register. Depends on ipaf_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module ipaf_dp
    import ipaf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ipaf_req_if.sink        req,
    ipaf_rsp_if.source      rsp,
    input  dp_cmd_t         cmd,
    output dp_status_t      status
);

    // Item registers
    logic        op_reg;
    logic [1:0]  fam_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic [31:0] ip;

    // Table state
    logic [31:0]      mem [TABLE_DEPTH];
    logic [31:0]      rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             found_reg;
    logic             mem_we;
    logic             hit;
    logic             last;
    logic             fixed_hit;
    logic             table_full;

    // Result register
    logic              out_valid_reg;
    logic              allowed_reg;
    logic [1:0]        status_reg;
    logic [USED_W-1:0] used_reg;
    logic              allowed_next;
    logic [1:0]        status_next;

    assign ip         = lo_reg[31:0];
    assign fixed_hit  = v4_fixed_allowed(ip);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit        = (rd_data_reg == ip);
    assign last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign status.need_scan = (fam_reg == FAM_V4) && (count_reg != '0)
                              && ((op_reg == OP_LEARN) || !fixed_hit);
    assign status.scan_done = hit || last;
    assign status.out_free  = !out_valid_reg || rsp.ready;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            fam_reg <= req.address_family;
            hi_reg  <= req.address_high;
            lo_reg  <= req.address_low;
        end
    end

    // Scan pointer: the read address follows its next value
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end
    assign rd_addr = idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                found_reg <= hit;
            end
        end
    end

    // Learned table: append at the fill count, read one entry a cycle
    assign mem_we = cmd.finish && (op_reg == OP_LEARN) && (fam_reg == FAM_V4)
                    && !found_reg && !table_full;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= ip;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign count_next = mem_we ? (count_reg + CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Form the result
    always_comb
    begin
        allowed_next = 1'b0;
        status_next  = LS_INSERTED;
        if (op_reg == OP_CHECK)
        begin
            unique case (fam_reg)
                FAM_NONE:  allowed_next = 1'b1;
                FAM_V4:    allowed_next = fixed_hit || found_reg;
                FAM_V6:    allowed_next = v6_allowed(hi_reg, lo_reg);
                FAM_OTHER: allowed_next = 1'b0;
                default:   allowed_next = 1'b0;
            endcase
        end
        else
        begin
            priority if (fam_reg != FAM_V4)
            begin
                status_next = LS_IGNORED;
            end
            else if (found_reg)
            begin
                status_next = LS_PRESENT;
            end
            else if (table_full)
            begin
                status_next = LS_FULL;
            end
            else
            begin
                status_next = LS_INSERTED;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            allowed_reg <= allowed_next;
            status_reg  <= status_next;
            used_reg    <= USED_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.allowed      = allowed_reg;
    assign rsp.learn_status = status_reg;
    assign rsp.entries_used = used_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || rsp.ready))
        else $error("result loaded over an untaken item");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance fill count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan beyond filled entries");

endmodule

`default_nettype wire

@@ rtl/ip_endpoint_allow_filter.sv @@
// Endpoint allow filter: one result item per request item, in order. An item needs no
// table search when it is any non-IPv4 item, an IPv4 check in a fixed range, or any IPv4
// item while the learned table is empty. Otherwise the search reads k learned entries,
// where k (1 to the number of entries held when the item arrives) is the number read
// before a match or the last filled entry, through the single read port of the learned
// table, one entry per cycle. The finish step waits while the previous result is still
// untaken. The table fills from entry 0 upward and is never pruned, so a fill count
// replaces per-entry valid bits and no clearing pass follows reset. A new item is
// accepted while the previous result still waits in the output register.
// Depends on ipaf_pkg, ipaf_if, ipaf_ctrl and ipaf_dp.
`timescale 1ns / 1ps
`default_nettype none

module ip_endpoint_allow_filter
    import ipaf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ipaf_req_if.sink    req,
    ipaf_rsp_if.source  rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ipaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ipaf_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
